// ===== hw/rtl/tlil_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlil_pkg
// shared types and constants of the two-level icache lookup unit
// ----------------------------------------------------------------------------
package tlil_pkg;

  localparam int PC_W = 30;
  localparam int CORE_W = 2;
  localparam int CNT_W = 32;

  typedef enum logic [1:0] {
    LVL_L1_HIT = 2'd0,
    LVL_L2_HIT = 2'd1,
    LVL_MISS   = 2'd2
  } level_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request, issue tag reads
    logic l1_eval;  // evaluate l1 set, issue l2 read
    logic finish;   // evaluate l2, write back, present result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
  } dp_status_t;

endpackage

// ===== hw/rtl/tlil_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlil_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module tlil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tlil_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlil_ctrl
// sequencer: reset clearing pass, then load, l1 and l2 steps per lookup
// ----------------------------------------------------------------------------
module tlil_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  tlil_pkg::dp_status_t status,
  output tlil_pkg::dp_cmd_t    cmd,
  output logic                 busy
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_L1    = 4'b0100,
    S_L2    = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (status.clear_done) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_L1;
      S_L1:    state_next = S_L2;
      S_L2:    state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign cmd.load = (state == S_IDLE) && start;
  assign cmd.l1_eval = (state == S_L1);
  assign cmd.finish = (state == S_L2);

endmodule

// ===== hw/rtl/tlil_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlil_dp
// tag/valid/age memories, hit detection, lru update and counters
// ----------------------------------------------------------------------------
module tlil_dp #(
  parameter int NUM_CORES  = 4,
  parameter int L1_WAYS    = 4,
  parameter int L2_WAYS    = 8,
  parameter int L1_SETS    = 64,
  parameter int L2_SETS    = 256,
  parameter int LINE_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tlil_pkg::dp_cmd_t             cmd,
  output tlil_pkg::dp_status_t          status,
  input  logic [tlil_pkg::PC_W-1:0]     pc,
  input  logic [tlil_pkg::CORE_W-1:0]   core_id,
  output logic                          done,
  output logic [1:0]                    hit_level,
  output logic [1:0]                    l1_way,
  output logic [2:0]                    l2_way,
  output logic [tlil_pkg::CNT_W-1:0]    core_l1_hits,
  output logic [tlil_pkg::CNT_W-1:0]    core_l1_misses,
  output logic [tlil_pkg::CNT_W-1:0]    l2_hit_count,
  output logic [tlil_pkg::CNT_W-1:0]    l2_miss_count
);

  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int LINE_W = 32 - OFF_W;
  localparam int S2_W   = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
  localparam int C_W    = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int W1_W   = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
  localparam int W2_W   = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int T1_W   = LINE_W - $clog2(L1_SETS);
  localparam int T2_W   = LINE_W - $clog2(L2_SETS);
  localparam int R1_N   = NUM_CORES * L1_SETS;
  localparam int R1_W   = (R1_N > 1) ? $clog2(R1_N) : 1;
  localparam int CLR_W  = ((R1_N > L2_SETS) ? R1_W : S2_W) + 1;
  localparam int ROW1_W = L1_WAYS * (1 + W1_W);
  localparam int ROW2_W = L2_WAYS * (1 + W2_W);

  // request registers
  logic [LINE_W-1:0] line;
  logic [C_W-1:0]    core;
  logic [R1_W-1:0]   r1;
  logic [S2_W-1:0]   r2;
  logic [T1_W-1:0]   tag1;
  logic [T2_W-1:0]   tag2;

  logic [31:0] addr;
  logic [C_W-1:0] core_in;
  logic [LINE_W-1:0] line_in;
  assign addr = {pc, 2'b00};
  assign line_in = addr[31:OFF_W];
  assign core_in = C_W'(32'(core_id) % NUM_CORES);

  assign tag1 = T1_W'(line >> $clog2(L1_SETS));
  assign tag2 = T2_W'(line >> $clog2(L2_SETS));

  // clearing pass over state rows
  logic [CLR_W-1:0] clr;
  logic clearing;
  assign clearing = (clr != '1) && !status.clear_done;
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      status.clear_done <= 1'b0;
    end else if (!status.clear_done) begin
      clr <= clr + 1'b1;
      if (clr == CLR_W'(((R1_N > L2_SETS) ? R1_N : L2_SETS) - 1)) status.clear_done <= 1'b1;
    end
  end

  function automatic logic [ROW1_W-1:0] row1_reset();
    logic [ROW1_W-1:0] r;
    r = '0;
    for (int w = 0; w < L1_WAYS; w++) r[w*(1+W1_W) +: W1_W] = W1_W'(w);
    return r;
  endfunction

  function automatic logic [ROW2_W-1:0] row2_reset();
    logic [ROW2_W-1:0] r;
    r = '0;
    for (int w = 0; w < L2_WAYS; w++) r[w*(1+W2_W) +: W2_W] = W2_W'(w);
    return r;
  endfunction

  // memories
  logic [R1_W-1:0] r1_raddr, r1_waddr;
  logic [S2_W-1:0] r2_raddr, r2_waddr;
  logic            s1_we, s2_we, t1_we, t2_we;
  logic [ROW1_W-1:0] s1_wd, s1_rd;
  logic [ROW2_W-1:0] s2_wd, s2_rd;
  logic [L1_WAYS*T1_W-1:0] t1_wd, t1_rd;
  logic [L2_WAYS*T2_W-1:0] t2_wd, t2_rd;

  always_comb begin
    if (cmd.load) begin
      r1_raddr = R1_W'(32'(core_in) * L1_SETS + 32'(line_in % L1_SETS));
      r2_raddr = S2_W'(line_in % L2_SETS);
    end else begin
      r1_raddr = r1;
      r2_raddr = r2;
    end
  end

  tlil_ram #(.WIDTH(ROW1_W), .DEPTH(R1_N)) u_s1 (
    .clk(clk), .we(s1_we), .waddr(r1_waddr), .wdata(s1_wd), .raddr(r1_raddr), .rdata(s1_rd));
  tlil_ram #(.WIDTH(ROW2_W), .DEPTH(L2_SETS)) u_s2 (
    .clk(clk), .we(s2_we), .waddr(r2_waddr), .wdata(s2_wd), .raddr(r2_raddr), .rdata(s2_rd));
  tlil_ram #(.WIDTH(L1_WAYS*T1_W), .DEPTH(R1_N)) u_t1 (
    .clk(clk), .we(t1_we), .waddr(r1), .wdata(t1_wd), .raddr(r1_raddr), .rdata(t1_rd));
  tlil_ram #(.WIDTH(L2_WAYS*T2_W), .DEPTH(L2_SETS)) u_t2 (
    .clk(clk), .we(t2_we), .waddr(r2), .wdata(t2_wd), .raddr(r2_raddr), .rdata(t2_rd));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      line <= line_in;
      core <= core_in;
      r1 <= R1_W'(32'(core_in) * L1_SETS + 32'(line_in % L1_SETS));
      r2 <= S2_W'(line_in % L2_SETS);
    end
  end

  // l1 evaluation, registered
  logic            l1_hit;
  logic [W1_W-1:0] w1h;
  logic [ROW1_W-1:0] s1_q;
  logic [L1_WAYS*T1_W-1:0] t1_q;
  logic l1_hit_c;
  logic [W1_W-1:0] w1h_c;
  always_comb begin
    l1_hit_c = 1'b0;
    w1h_c = '0;
    for (int w = L1_WAYS - 1; w >= 0; w--) begin
      if (s1_rd[w*(1+W1_W)+W1_W] && t1_rd[w*T1_W +: T1_W] == tag1) begin
        l1_hit_c = 1'b1;
        w1h_c = W1_W'(w);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.l1_eval) begin
      l1_hit <= l1_hit_c;
      w1h <= w1h_c;
      s1_q <= s1_rd;
      t1_q <= t1_rd;
    end
  end

  // final evaluation
  logic            l2_hit;
  logic [W2_W-1:0] w2h, w2v, w2;
  logic [W1_W-1:0] w1v, w1;
  logic [W1_W-1:0] a1_old;
  logic [W2_W-1:0] a2_old;
  always_comb begin
    l2_hit = 1'b0;
    w2h = '0;
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      if (s2_rd[w*(1+W2_W)+W2_W] && t2_rd[w*T2_W +: T2_W] == tag2) begin
        l2_hit = 1'b1;
        w2h = W2_W'(w);
      end
    end
    // victims: lowest invalid way, else oldest (age == ways-1)
    w2v = '0;
    for (int w = L2_WAYS - 1; w >= 0; w--)
      if (s2_rd[w*(1+W2_W) +: W2_W] == W2_W'(L2_WAYS - 1)) w2v = W2_W'(w);
    for (int w = L2_WAYS - 1; w >= 0; w--)
      if (!s2_rd[w*(1+W2_W)+W2_W]) w2v = W2_W'(w);
    w1v = '0;
    for (int w = L1_WAYS - 1; w >= 0; w--)
      if (s1_q[w*(1+W1_W) +: W1_W] == W1_W'(L1_WAYS - 1)) w1v = W1_W'(w);
    for (int w = L1_WAYS - 1; w >= 0; w--)
      if (!s1_q[w*(1+W1_W)+W1_W]) w1v = W1_W'(w);
    w2 = l2_hit ? w2h : w2v;
    w1 = l1_hit ? w1h : w1v;
    a1_old = s1_q[32'(w1)*(1+W1_W) +: W1_W];
    a2_old = s2_rd[32'(w2)*(1+W2_W) +: W2_W];
  end

  // write-back rows
  always_comb begin
    s1_wd = s1_q;
    for (int w = 0; w < L1_WAYS; w++)
      if (s1_q[w*(1+W1_W) +: W1_W] < a1_old)
        s1_wd[w*(1+W1_W) +: W1_W] = s1_q[w*(1+W1_W) +: W1_W] + 1'b1;
    s1_wd[32'(w1)*(1+W1_W) +: W1_W] = '0;
    s1_wd[32'(w1)*(1+W1_W)+W1_W] = 1'b1;
    s2_wd = s2_rd;
    for (int w = 0; w < L2_WAYS; w++)
      if (s2_rd[w*(1+W2_W) +: W2_W] < a2_old)
        s2_wd[w*(1+W2_W) +: W2_W] = s2_rd[w*(1+W2_W) +: W2_W] + 1'b1;
    s2_wd[32'(w2)*(1+W2_W) +: W2_W] = '0;
    s2_wd[32'(w2)*(1+W2_W)+W2_W] = 1'b1;
    t1_wd = t1_q;
    t1_wd[32'(w1)*T1_W +: T1_W] = tag1;
    t2_wd = t2_rd;
    t2_wd[32'(w2)*T2_W +: T2_W] = tag2;
    if (clearing) begin
      s1_wd = row1_reset();
      s2_wd = row2_reset();
    end
  end

  always_comb begin
    if (clearing) begin
      r1_waddr = R1_W'(clr);
      r2_waddr = S2_W'(clr);
      s1_we = 32'(clr) < R1_N;
      s2_we = 32'(clr) < L2_SETS;
    end else begin
      r1_waddr = r1;
      r2_waddr = r2;
      s1_we = cmd.finish;
      s2_we = cmd.finish && !l1_hit;
    end
  end
  assign t1_we = cmd.finish && !l1_hit;
  assign t2_we = cmd.finish && !l1_hit && !l2_hit;

  // counters
  logic [tlil_pkg::CNT_W-1:0] hits [NUM_CORES];
  logic [tlil_pkg::CNT_W-1:0] miss [NUM_CORES];
  logic [tlil_pkg::CNT_W-1:0] l2h, l2m;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CORES; c++) begin
        hits[c] <= '0;
        miss[c] <= '0;
      end
      l2h <= '0;
      l2m <= '0;
    end else if (cmd.finish) begin
      if (l1_hit) hits[core] <= hits[core] + 1'b1;
      else miss[core] <= miss[core] + 1'b1;
      if (!l1_hit && l2_hit) l2h <= l2h + 1'b1;
      if (!l1_hit && !l2_hit) l2m <= l2m + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hit_level <= l1_hit ? tlil_pkg::LVL_L1_HIT :
                   (l2_hit ? tlil_pkg::LVL_L2_HIT : tlil_pkg::LVL_MISS);
      l1_way <= 2'(w1);
      l2_way <= l1_hit ? 3'd0 : 3'(w2);
      core_l1_hits <= l1_hit ? hits[core] + 1'b1 : hits[core];
      core_l1_misses <= l1_hit ? miss[core] : miss[core] + 1'b1;
      l2_hit_count <= (!l1_hit && l2_hit) ? l2h + 1'b1 : l2h;
      l2_miss_count <= (!l1_hit && !l2_hit) ? l2m + 1'b1 : l2m;
    end
  end

endmodule

// ===== hw/rtl/two_level_icache_lookup_lru_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_icache_lookup_lru_unit
// tag-only model of instruction fetch through private l1s and a shared l2
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over the lru/valid rows, one row
// per cycle, and holds busy high until it is through. Then each word is
// taken when start is high and busy is low; it steps through the l1 step and
// the l2 step, and its result is registered onto the result ports with done
// high for one cycle. Busy stays high until then, so a new word can be taken
// no sooner than the cycle in which done shows. The steps are the l1 set read,
// the l2 set read and the row write-back, each through registered-read
// memories. The receiver cannot stall: results must be taken when done shows.
module two_level_icache_lookup_lru_unit #(
  parameter int NUM_CORES  = 4,
  parameter int L1_WAYS    = 4,
  parameter int L2_WAYS    = 8,
  parameter int L1_SETS    = 64,
  parameter int L2_SETS    = 256,
  parameter int LINE_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [29:0] pc,
  input  logic [1:0]  core_id,
  output logic        done,
  output logic [1:0]  hit_level,
  output logic [1:0]  l1_way,
  output logic [2:0]  l2_way,
  output logic [31:0] core_l1_hits,
  output logic [31:0] core_l1_misses,
  output logic [31:0] l2_hit_count,
  output logic [31:0] l2_miss_count
);

  // command and status between sequencer and datapath
  tlil_pkg::dp_cmd_t    cmd;
  tlil_pkg::dp_status_t status;

  tlil_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .status(status), .cmd(cmd), .busy(busy));

  tlil_dp #(
    .NUM_CORES(NUM_CORES), .L1_WAYS(L1_WAYS), .L2_WAYS(L2_WAYS),
    .L1_SETS(L1_SETS), .L2_SETS(L2_SETS), .LINE_BYTES(LINE_BYTES)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .pc(pc), .core_id(core_id),
    .done(done), .hit_level(hit_level), .l1_way(l1_way), .l2_way(l2_way),
    .core_l1_hits(core_l1_hits), .core_l1_misses(core_l1_misses),
    .l2_hit_count(l2_hit_count), .l2_miss_count(l2_miss_count));

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the two-level icache lookup unit: a driver sends
// fetch words from a queue, a tag/lru predictor computes each expected
// result, and a monitor compares every done strobe against it
// ----------------------------------------------------------------------------
module tb_top;

  localparam int N_CORES = 4;
  localparam int L1W = 4;
  localparam int L2W = 8;
  localparam int L1S = 64;
  localparam int L2S = 256;
  localparam int LBYTES = 64;
  localparam int N_RANDOM = 1500;

  typedef struct {
    logic [29:0] pc;
    logic [1:0]  core;
  } fetch_t;

  typedef struct {
    tlil_pkg::level_t lvl;
    logic [1:0]  w1;
    logic [2:0]  w2;
    logic [31:0] c_hits;
    logic [31:0] c_misses;
    logic [31:0] l2_hits;
    logic [31:0] l2_misses;
  } lookup_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [29:0] pc = '0;
  logic [1:0]  core_id = '0;
  logic        busy, done;
  logic [1:0]  hit_level, l1_way;
  logic [2:0]  l2_way;
  logic [31:0] core_l1_hits, core_l1_misses, l2_hit_count, l2_miss_count;

  two_level_icache_lookup_lru_unit u_top (
    .clk, .rst, .start, .busy, .pc, .core_id, .done, .hit_level, .l1_way,
    .l2_way, .core_l1_hits, .core_l1_misses, .l2_hit_count, .l2_miss_count
  );

  always #6 clk = ~clk;

  // predictor state, flat like the hardware rows: [core][set][way]
  logic [19:0] p1_tag [N_CORES*L1S*L1W];
  bit          p1_vld [N_CORES*L1S*L1W];
  logic [1:0]  p1_age [N_CORES*L1S*L1W];
  logic [17:0] p2_tag [L2S*L2W];
  bit          p2_vld [L2S*L2W];
  logic [2:0]  p2_age [L2S*L2W];
  logic [31:0] p1_hits [N_CORES];
  logic [31:0] p1_miss [N_CORES];
  logic [31:0] p2_hits, p2_miss;

  fetch_t      pending_words[$];
  lookup_res_t expected_results[$];
  int          n_errors = 0;
  int          idle_left = 0;
  bit          no_idle = 1'b0;
  bit          hold_send = 1'b0;
  bit          stim_done = 1'b0;

  function automatic void predictor_clear();
    for (int i = 0; i < N_CORES*L1S*L1W; i++) begin
      p1_vld[i] = 0;
      p1_age[i] = 2'(i % L1W);
    end
    for (int i = 0; i < L2S*L2W; i++) begin
      p2_vld[i] = 0;
      p2_age[i] = 3'(i % L2W);
    end
    for (int c = 0; c < N_CORES; c++) begin
      p1_hits[c] = '0;
      p1_miss[c] = '0;
    end
    p2_hits = '0;
    p2_miss = '0;
  endfunction

  // make one way most recent within an l1 set
  function automatic void touch_l1(int base, int w);
    logic [1:0] old;
    old = p1_age[base+w];
    for (int i = 0; i < L1W; i++)
      if (p1_age[base+i] < old) p1_age[base+i]++;
    p1_age[base+w] = '0;
  endfunction

  function automatic void touch_l2(int base, int w);
    logic [2:0] old;
    old = p2_age[base+w];
    for (int i = 0; i < L2W; i++)
      if (p2_age[base+i] < old) p2_age[base+i]++;
    p2_age[base+w] = '0;
  endfunction

  function automatic lookup_res_t predict_fetch(fetch_t f);
    lookup_res_t r;
    logic [31:0] line;
    int c, b1, b2, w1, w2;
    line = {f.pc, 2'b00} / LBYTES;
    c = f.core % N_CORES;
    b1 = (c*L1S + line % L1S) * L1W;
    b2 = (line % L2S) * L2W;
    w1 = -1;
    w2 = 0;
    for (int i = 0; i < L1W; i++)
      if (w1 < 0 && p1_vld[b1+i] && p1_tag[b1+i] == 20'(line / L1S)) w1 = i;
    if (w1 >= 0) begin
      r.lvl = tlil_pkg::LVL_L1_HIT;
      p1_hits[c]++;
      touch_l1(b1, w1);
    end else begin
      p1_miss[c]++;
      w2 = -1;
      for (int i = 0; i < L2W; i++)
        if (w2 < 0 && p2_vld[b2+i] && p2_tag[b2+i] == 18'(line / L2S)) w2 = i;
      if (w2 >= 0) begin
        r.lvl = tlil_pkg::LVL_L2_HIT;
        p2_hits++;
      end else begin
        r.lvl = tlil_pkg::LVL_MISS;
        p2_miss++;
        for (int i = L2W-1; i >= 0; i--) if (!p2_vld[b2+i]) w2 = i;
        if (w2 < 0) begin
          w2 = 0;
          for (int i = 1; i < L2W; i++) if (p2_age[b2+i] > p2_age[b2+w2]) w2 = i;
        end
        p2_tag[b2+w2] = 18'(line / L2S);
        p2_vld[b2+w2] = 1;
      end
      touch_l2(b2, w2);
      // l1 victim: lowest invalid way, else the oldest
      w1 = -1;
      for (int i = L1W-1; i >= 0; i--) if (!p1_vld[b1+i]) w1 = i;
      if (w1 < 0) begin
        w1 = 0;
        for (int i = 1; i < L1W; i++) if (p1_age[b1+i] > p1_age[b1+w1]) w1 = i;
      end
      p1_tag[b1+w1] = 20'(line / L1S);
      p1_vld[b1+w1] = 1;
      touch_l1(b1, w1);
    end
    r.w1 = w1[1:0];
    r.w2 = w2[2:0];
    r.c_hits = p1_hits[c];
    r.c_misses = p1_miss[c];
    r.l2_hits = p2_hits;
    r.l2_misses = p2_miss;
    return r;
  endfunction

  // driver: one word from the queue per handshake, with random idle bursts
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(predict_fetch('{pc, core_id}));
        void'(pending_words.pop_front());
      end
      if (start && busy) begin
        // word still on offer
      end else if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        idle_left <= $urandom_range(0, 2);
        start <= 1'b0;
      end else if (hold_send || pending_words.size() == 0) begin
        start <= 1'b0;
      end else begin
        // any accepted word is already popped, so the next one is entry 0
        start <= 1'b1;
        pc <= pending_words[0].pc;
        core_id <= pending_words[0].core;
      end
    end
  end

  // monitor: every done strobe must match the oldest expectation
  always @(posedge clk) begin
    lookup_res_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result word at %0t", $realtime);
      end else begin
        e = expected_results.pop_front();
        if (hit_level !== e.lvl || l1_way !== e.w1 || l2_way !== e.w2 ||
            core_l1_hits !== e.c_hits || core_l1_misses !== e.c_misses ||
            l2_hit_count !== e.l2_hits || l2_miss_count !== e.l2_misses) begin
          n_errors++;
          if (n_errors <= 10)
            $display({"mismatch: exp lvl%0d w%0d/%0d c%0d/%0d l2 %0d/%0d",
                      " got lvl%0d w%0d/%0d c%0d/%0d l2 %0d/%0d"},
                     e.lvl, e.w1, e.w2, e.c_hits, e.c_misses, e.l2_hits, e.l2_misses,
                     hit_level, l1_way, l2_way, core_l1_hits, core_l1_misses,
                     l2_hit_count, l2_miss_count);
        end
      end
    end
  end

  function automatic void add_word(logic [29:0] p, logic [1:0] c);
    pending_words.push_back('{p, c});
  endfunction

  initial begin
    logic [29:0] p;
    predictor_clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, every core, l1 hit, l2 hit, both-miss, eviction
    add_word('0, 2'd0);
    add_word('0, 2'd0);                    // l1 hit
    add_word('0, 2'd1);                    // l2 hit through another core
    add_word('1, 2'd3);
    add_word('1, 2'd3);
    add_word(30'h2AAAAAAA, 2'd2);
    add_word(30'h15555555, 2'd1);
    // six lines in one l1 set of core 0: fills, then evicts the oldest
    for (int i = 0; i < 6; i++) add_word(30'(i * L1S * 16), 2'd0);
    add_word(30'(0), 2'd0);
    // ten lines in one l2 set: evicts in l2 too
    for (int i = 0; i < 10; i++) add_word(30'(i * L2S * 16 + 5*16), 2'd2);
    add_word(30'(5*16), 2'd2);
    wait (pending_words.size() == 0);
    // pause until every expected result is back
    hold_send = 1'b1;
    wait (expected_results.size() == 0);
    repeat (8) @(posedge clk);
    hold_send = 1'b0;

    // random: mostly a small hot region so hits and evictions recur
    for (int n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(0, 9))
        0: p = 30'($urandom());
        1, 2: p = 30'($urandom_range(0, 7) * L2S * 16 + $urandom_range(0, 31));
        default: p = 30'($urandom_range(0, 3) * L1S * 16 * 5 + $urandom_range(0, 2047));
      endcase
      add_word(p, 2'($urandom_range(0, 3)));
      if (n == N_RANDOM - 200) no_idle = 1'b1;
      if (n % 100 == 99) wait (pending_words.size() < 20);
    end
    wait (pending_words.size() == 0);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // generous cap on run time: clearing pass plus ~1550 words
  initial begin
    #(12 * 200000);
    $display("simulation failed");
    $finish;
  end

endmodule
